// File: hw/rtl/rc4ks_pkg.sv
package rc4ks_pkg;

    // Table geometry and the default key store depth.
    localparam int TABLE_SIZE      = 256;
    localparam int MAX_KEY_DEFAULT = 256;
    localparam logic [7:0] BYTE_LAST = 8'hFF;

    // Step counter codes of the control program.
    typedef logic [3:0] t_step;
    localparam t_step S_IDLE = 4'd0;
    localparam t_step S_D1   = 4'd1;
    localparam t_step S_D2   = 4'd2;
    localparam t_step S_D3   = 4'd3;
    localparam t_step S_INIT = 4'd4;
    localparam t_step S_KS0  = 4'd5;
    localparam t_step S_KS1  = 4'd6;
    localparam t_step S_KS2  = 4'd7;
    localparam t_step S_KS3  = 4'd8;

    // Table read address sources.
    typedef enum logic [2:0] {
        RA_INEXT,
        RA_JDATA,
        RA_JKS,
        RA_TSUM,
        RA_N,
        RA_T
    } t_raddr;

    // Table write address sources.
    typedef enum logic [1:0] {
        WA_I,
        WA_J,
        WA_N
    } t_waddr;

    // Table write data sources.
    typedef enum logic [1:0] {
        WD_N,
        WD_RD,
        WD_SI
    } t_wdata;

    // Update of the j index.
    typedef enum logic [1:0] {
        JOP_HOLD,
        JOP_DATA,
        JOP_KS
    } t_jop;

    // Jump conditions.
    typedef enum logic [1:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_N_END,
        C_OUT_FREE
    } t_cond;

    // One control word.
    typedef struct packed {
        t_raddr raddr;
        t_waddr waddr;
        t_wdata wdata;
        logic   tab_we;
        t_jop   jop;
        logic   ld_si;
        logic   ld_sj;
        logic   n_inc;
        logic   k_inc;
        logic   out_ld;
        logic   clr_ij;
        t_cond  cond;
        t_step  t_true;
        t_step  t_false;
    } t_uword;

    // The control program. Flags gated by a condition act only when it holds.
    function automatic t_uword rc4ks_ucode(input t_step step);
        t_uword w;
        w = '{raddr: RA_INEXT, waddr: WA_I, wdata: WD_RD, tab_we: 1'b0,
              jop: JOP_HOLD, ld_si: 1'b0, ld_sj: 1'b0, n_inc: 1'b0,
              k_inc: 1'b0, out_ld: 1'b0, clr_ij: 1'b0, cond: C_DISPATCH,
              t_true: S_IDLE, t_false: S_IDLE};
        case (step)
            S_IDLE: begin
                w.raddr = RA_INEXT;
                w.cond  = C_DISPATCH;
            end
            S_D1: begin
                w.raddr  = RA_JDATA;
                w.jop    = JOP_DATA;
                w.ld_si  = 1'b1;
                w.cond   = C_ALWAYS;
                w.t_true = S_D2;
            end
            S_D2: begin
                w.raddr  = RA_TSUM;
                w.waddr  = WA_I;
                w.wdata  = WD_RD;
                w.tab_we = 1'b1;
                w.ld_sj  = 1'b1;
                w.cond   = C_ALWAYS;
                w.t_true = S_D3;
            end
            S_D3: begin
                // Re-read the keystream entry so a held result keeps it.
                w.raddr   = RA_T;
                w.waddr   = WA_J;
                w.wdata   = WD_SI;
                w.tab_we  = 1'b1;
                w.out_ld  = 1'b1;
                w.cond    = C_OUT_FREE;
                w.t_true  = S_IDLE;
                w.t_false = S_D3;
            end
            S_INIT: begin
                w.waddr   = WA_N;
                w.wdata   = WD_N;
                w.tab_we  = 1'b1;
                w.n_inc   = 1'b1;
                w.cond    = C_N_END;
                w.t_true  = S_KS0;
                w.t_false = S_INIT;
            end
            S_KS0: begin
                w.raddr  = RA_N;
                w.cond   = C_ALWAYS;
                w.t_true = S_KS1;
            end
            S_KS1: begin
                w.raddr  = RA_JKS;
                w.jop    = JOP_KS;
                w.ld_si  = 1'b1;
                w.cond   = C_ALWAYS;
                w.t_true = S_KS2;
            end
            S_KS2: begin
                w.waddr  = WA_N;
                w.wdata  = WD_RD;
                w.tab_we = 1'b1;
                w.cond   = C_ALWAYS;
                w.t_true = S_KS3;
            end
            S_KS3: begin
                w.waddr   = WA_J;
                w.wdata   = WD_SI;
                w.tab_we  = 1'b1;
                w.n_inc   = 1'b1;
                w.k_inc   = 1'b1;
                w.clr_ij  = 1'b1;
                w.cond    = C_N_END;
                w.t_true  = S_IDLE;
                w.t_false = S_KS0;
            end
            default: begin
                w.cond = C_DISPATCH;
            end
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/rc4_keystream_cipher.sv
// RC4 cipher. Each input request carries kind, value and last. A key request
// (kind 0) stores one key byte; a key request with last set then runs the
// key schedule: table initialization over all 256 entries and 256 swap
// steps, each through KS0 to KS3, before the next request is taken. A data
// request (kind 1) is XORed with the next keystream byte; encryption and
// decryption are the same operation. The result request (data_out,
// last_out) is loaded into the output register at S_D3, after S_D1 and
// S_D2, and the next data byte is taken only once the program returns to
// S_IDLE. The data steps run in series because of the single read port and
// single write port of the permutation table: each byte needs three
// dependent reads and two writes into it. Key requests give no result.
// A small control program drives the datapath; the input is stalled
// whenever the program is not at its idle step. A result waits in the
// output register while the receiver stalls; the next data request may be
// accepted meanwhile and then holds at its last step until the register
// frees up. Reset clears the indices, the key count and the output valid;
// the table is undefined until the first key schedule.
module rc4_keystream_cipher
    import rc4ks_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_value,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_data_out,
    output logic       o_last_out
);

    localparam int CW = $clog2(MAX_KEY_BYTES + 1);
    localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [CW-1:0] KEY_MAX = CW'(MAX_KEY_BYTES);

    // Memories.
    logic [7:0] r_perm [TABLE_SIZE];
    logic [7:0] r_key  [MAX_KEY_BYTES];

    // Sequencer and datapath registers.
    t_step        r_step;
    t_step        n_step;
    logic [7:0]   r_i;
    logic [7:0]   r_j;
    logic [7:0]   r_n;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_key_count;
    logic [CW-1:0] r_len;
    logic [7:0]   r_rd;
    logic [7:0]   r_key_rd;
    logic [7:0]   r_si;
    logic [7:0]   r_sj;
    logic [7:0]   r_t;
    logic [7:0]   r_value;
    logic         r_last;
    logic         r_out_valid;
    logic [7:0]   r_data_out;
    logic         r_last_out;

    t_uword     uw;
    logic       in_acc;
    logic       out_free;
    logic       cond_ok;
    logic       out_load;
    logic       k_wrap;
    logic [7:0] w_j_data;
    logic [7:0] w_j_ks;
    logic [7:0] w_tsum;
    logic [7:0] w_raddr;
    logic [7:0] w_waddr;
    logic [7:0] w_wdata;
    logic [7:0] w_ks;

    assign uw       = rc4ks_ucode(r_step);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = uw.out_ld && out_free;

    assign o_in_stall  = (r_step != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_last_out  = r_last_out;

    // Index sums used as table addresses.
    assign w_j_data = r_j + r_rd;
    assign w_j_ks   = r_j + r_key_rd + r_rd;
    assign w_tsum   = r_si + r_rd;
    assign k_wrap   = ((CW + 1)'(r_k) + (CW + 1)'(1)) == {1'b0, r_len};

    // Condition evaluation and next step.
    always_comb begin
        cond_ok = 1'b0;
        n_step  = S_IDLE;
        case (uw.cond)
            C_ALWAYS: begin
                cond_ok = 1'b1;
                n_step  = uw.t_true;
            end
            C_DISPATCH: begin
                if (in_acc && i_kind) begin
                    n_step = S_D1;
                end else if (in_acc && i_last) begin
                    n_step = S_INIT;
                end else begin
                    n_step = S_IDLE;
                end
            end
            C_N_END: begin
                cond_ok = (r_n == BYTE_LAST);
                n_step  = cond_ok ? uw.t_true : uw.t_false;
            end
            C_OUT_FREE: begin
                cond_ok = out_free;
                n_step  = cond_ok ? uw.t_true : uw.t_false;
            end
            default: begin
                n_step = S_IDLE;
            end
        endcase
    end

    // Table address and data selection.
    always_comb begin
        case (uw.raddr)
            RA_INEXT: w_raddr = r_i + 8'd1;
            RA_JDATA: w_raddr = w_j_data;
            RA_JKS:   w_raddr = w_j_ks;
            RA_TSUM:  w_raddr = w_tsum;
            RA_N:     w_raddr = r_n;
            RA_T:     w_raddr = r_t;
            default:  w_raddr = r_n;
        endcase
        case (uw.waddr)
            WA_I:    w_waddr = r_i;
            WA_J:    w_waddr = r_j;
            WA_N:    w_waddr = r_n;
            default: w_waddr = r_n;
        endcase
        case (uw.wdata)
            WD_N:    w_wdata = r_n;
            WD_RD:   w_wdata = r_rd;
            WD_SI:   w_wdata = r_si;
            default: w_wdata = r_rd;
        endcase
    end

    // The keystream read was issued while S[i] was being written and before
    // S[j] was; take the swapped value when it hits either entry.
    always_comb begin
        if (r_t == r_i) begin
            w_ks = r_sj;
        end else if (r_t == r_j) begin
            w_ks = r_si;
        end else begin
            w_ks = r_rd;
        end
    end

    // Permutation table: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (uw.tab_we) begin
            r_perm[w_waddr] <= w_wdata;
        end
        r_rd <= r_perm[w_raddr];
    end

    // Key store: written by key requests, read at the schedule's key index.
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_kind && (r_key_count < KEY_MAX)) begin
            r_key[r_key_count[KW-1:0]] <= i_value;
        end
        r_key_rd <= r_key[r_k];
    end

    // Datapath temporaries.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_value <= i_value;
            r_last  <= i_last;
        end
        if (uw.ld_si) begin
            r_si <= r_rd;
        end
        if (uw.ld_sj) begin
            r_sj <= r_rd;
            r_t  <= w_tsum;
        end
        if (out_load) begin
            r_data_out <= r_value ^ w_ks;
            r_last_out <= r_last;
        end
    end

    // Sequencer, indices, key count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_key_count <= '0;
            r_len       <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;

            // Request dispatch.
            if (in_acc && i_kind) begin
                r_i <= r_i + 8'd1;
            end
            if (in_acc && !i_kind) begin
                if (i_last) begin
                    r_key_count <= '0;
                    r_len       <= (r_key_count < KEY_MAX) ? r_key_count + CW'(1)
                                                           : KEY_MAX;
                    r_j         <= '0;
                    r_n         <= '0;
                    r_k         <= '0;
                end else if (r_key_count < KEY_MAX) begin
                    r_key_count <= r_key_count + CW'(1);
                end
            end

            // Index updates from the control word.
            case (uw.jop)
                JOP_DATA: r_j <= w_j_data;
                JOP_KS:   r_j <= w_j_ks;
                default: begin
                end
            endcase
            if (uw.n_inc) begin
                r_n <= r_n + 8'd1;
            end
            if (uw.k_inc) begin
                r_k <= k_wrap ? '0 : KW'(r_k + KW'(1));
            end
            if (uw.clr_ij && cond_ok) begin
                r_i <= '0;
                r_j <= '0;
            end

            // Output register.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A data request always enters the data program.
    a_data_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind) |=> (r_step == S_D1))
        else $error("data request did not enter the data program");

    // The table is never written at the idle step.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_IDLE) |-> !uw.tab_we)
        else $error("table written while idle");

    // A result that cannot be stored holds the last data step.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == S_D3) && r_out_valid && i_out_stall) |=> (r_step == S_D3))
        else $error("result step left while output register busy");

    // The key length used by the schedule is never zero.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_KS3) |-> (r_len != '0))
        else $error("key schedule running with zero key length");

endmodule

// File: tb/rc4_keystream_cipher_tb.sv
`timescale 1ns / 1ps

module rc4_keystream_cipher_tb;
    import rc4ks_pkg::*;

    // Request kinds on the input channel.
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam int KEY_LIMIT      = MAX_KEY_DEFAULT;
    localparam int IDLE_LIMIT     = 20000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_cipher_out;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_kind      = 1'b0;
    logic [7:0] i_value     = 8'h00;
    logic       i_last      = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_data_out;
    logic       o_last_out;

    // Shadow copy of the cipher state.
    logic [7:0]  perm [TABLE_SIZE];
    logic [7:0]  key_bytes [TABLE_SIZE];
    int unsigned key_len = 0;
    logic [7:0]  idx_i = 8'h00;
    logic [7:0]  idx_j = 8'h00;

    t_cipher_out pending_bytes [$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    rc4_keystream_cipher #(
        .MAX_KEY_BYTES(KEY_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_data_out (o_data_out),
        .o_last_out (o_last_out)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Random backpressure on the result channel.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Key schedule: identity table, then 256 swaps cycling through the key.
    function automatic void rc4_rekey(input int unsigned len);
        logic [7:0]  j;
        logic [7:0]  tmp;
        int unsigned k;
        j = 8'h00;
        k = 0;
        if (len == 0) len = 1;
        if (len > KEY_LIMIT) len = KEY_LIMIT;
        for (int n = 0; n < TABLE_SIZE; n++) perm[n] = n[7:0];
        for (int n = 0; n < TABLE_SIZE; n++) begin
            j = j + key_bytes[k] + perm[n];
            tmp = perm[n];
            perm[n] = perm[j];
            perm[j] = tmp;
            k++;
            if (k >= len) k = 0;
        end
        idx_i = 8'h00;
        idx_j = 8'h00;
    endfunction

    // Update the shadow state for one accepted request and queue its result.
    function automatic void rc4_apply_request(input logic kind, input logic [7:0] value,
                                              input logic last);
        logic [7:0]  tmp;
        logic [7:0]  sum;
        t_cipher_out exp_byte;
        if (kind == KIND_KEY) begin
            if (key_len < KEY_LIMIT) begin
                key_bytes[key_len] = value;
                key_len++;
            end
            if (last) begin
                rc4_rekey(key_len);
                key_len = 0;
            end
        end else begin
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + perm[idx_i];
            tmp = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = tmp;
            sum = perm[idx_i] + perm[idx_j];
            exp_byte.data = value ^ perm[sum];
            exp_byte.last = last;
            pending_bytes.push_back(exp_byte);
        end
    endfunction

    // Drive one request, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_request(input logic kind, input logic [7:0] value, input logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_value    <= value;
        i_last     <= last;
        do @(posedge i_clk); while (o_in_stall);
        rc4_apply_request(kind, value, last);
    endtask

    // Compare each accepted result with the oldest expected byte.
    always @(posedge i_clk) begin
        t_cipher_out exp_byte;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: data_out=%02h last_out=%0b",
                             o_data_out, o_last_out);
            end else begin
                exp_byte = pending_bytes.pop_front();
                if (o_data_out !== exp_byte.data || o_last_out !== exp_byte.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected data_out=%02h last_out=%0b, got %02h %0b",
                                 exp_byte.data, exp_byte.last, o_data_out, o_last_out);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // A one-byte key at both value extremes, each followed by data.
    task automatic test_single_byte_key();
        send_request(KIND_KEY, 8'h00, 1'b1);
        send_request(KIND_DATA, 8'h00, 1'b0);
        send_request(KIND_DATA, 8'hFF, 1'b0);
        send_request(KIND_DATA, 8'h5A, 1'b1);
        send_request(KIND_KEY, 8'hFF, 1'b1);
        send_request(KIND_DATA, 8'hA5, 1'b0);
        send_request(KIND_DATA, 8'h00, 1'b1);
        send_request(KIND_DATA, 8'hFF, 1'b1);
    endtask

    // Data sent while a key is half loaded uses the old table and indices.
    task automatic test_key_in_progress();
        send_request(KIND_KEY, 8'h01, 1'b0);
        send_request(KIND_KEY, 8'h80, 1'b0);
        send_request(KIND_DATA, 8'h3C, 1'b1);
        send_request(KIND_DATA, 8'hC3, 1'b0);
        send_request(KIND_KEY, 8'h7F, 1'b1);
        send_request(KIND_DATA, 8'h11, 1'b0);
        send_request(KIND_DATA, 8'hEE, 1'b0);
        send_request(KIND_DATA, 8'h96, 1'b1);
    endtask

    // A key that fills the store exactly, then one whose surplus bytes are dropped.
    task automatic test_full_key_store();
        for (int n = 0; n < KEY_LIMIT; n++)
            send_request(KIND_KEY, 8'($urandom_range(0, 255)), n == KEY_LIMIT - 1);
        for (int n = 0; n < 4; n++)
            send_request(KIND_DATA, 8'($urandom_range(0, 255)), n == 3);
        for (int n = 0; n < KEY_LIMIT + 3; n++)
            send_request(KIND_KEY, 8'($urandom_range(0, 255)), n == KEY_LIMIT + 2);
        for (int n = 0; n < 4; n++)
            send_request(KIND_DATA, 8'($urandom_range(0, 255)), n == 3);
    endtask

    // Mostly key-then-message sequences with random content, plus stray requests.
    task automatic test_random_traffic(input int item_goal);
        int sent;
        int klen;
        int run_len;
        sent = 0;
        while (sent < item_goal) begin
            if ($urandom_range(0, 99) < 12) begin
                send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                sent++;
            end else begin
                klen = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16)
                                                    : $urandom_range(17, 64);
                for (int k = 0; k < klen; k++) begin
                    if (k != 0 && $urandom_range(0, 99) < 5) begin
                        send_request(KIND_DATA, 8'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1)));
                        sent++;
                    end
                    send_request(KIND_KEY, 8'($urandom_range(0, 255)), k == klen - 1);
                    sent++;
                end
                run_len = $urandom_range(1, 40);
                for (int n = 0; n < run_len; n++)
                    send_request(KIND_DATA, 8'($urandom_range(0, 255)), n == run_len - 1);
                sent += run_len;
            end
        end
    endtask

    // Test sequence.
    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 49;
        test_single_byte_key();
        test_key_in_progress();
        test_full_key_store();
        test_random_traffic(RANDOM_ITEMS);

        send_idle_pct = 49;
        recv_idle_pct = 15;
        test_random_traffic(RANDOM_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_bytes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
